// ===== sv/stp_pkg.sv =====
// Shared types and constants for the servo teach and playback sequencer.
`default_nettype none
package stp_pkg;

   // Widths fixed by the item fields and the register file.
   localparam int PULSE_W    = 16;
   localparam int CHAN_W     = 2;
   localparam int KEY_W      = 8;
   localparam int NUM_JOINTS = 4;
   localparam int NUM_LIMITS = 8;
   localparam int CSR_ADDR_W = 4;
   // Wide enough for any store index or count up to 63, which covers the default depth of 32.
   localparam int IDX_W      = 6;

   // Key codes.
   localparam logic [KEY_W-1:0] KEY_ACCEPT = 8'h88;
   localparam logic [KEY_W-1:0] KEY_REJECT = 8'h83;
   localparam logic [KEY_W-1:0] KEY_RECALL = 8'hA1;
   localparam logic [KEY_W-1:0] KEY_CLEAR  = 8'hF0;
   localparam logic [KEY_W-1:0] KEY_EXIT   = 8'hC0;

   // Per joint step keys, joint 0 in the lowest byte.
   localparam logic [NUM_JOINTS-1:0][KEY_W-1:0] DOWN_KEYS = {8'h90, 8'hF8, 8'h80, 8'h99};
   localparam logic [NUM_JOINTS-1:0][KEY_W-1:0] UP_KEYS   = {8'hB0, 8'hCF, 8'hA4, 8'h82};

   // Commands passed from the front end to the back end.
   typedef enum logic [1:0] {
      CMD_EMIT,
      CMD_STORE,
      CMD_RECALL
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type          op;
      logic                kind;
      logic [CHAN_W-1:0]   channel;
      logic [PULSE_W-1:0]  pulse;
      logic                dropped;
      logic [IDX_W-1:0]    index;
      logic [IDX_W-1:0]    count;
   } cmd_type;

endpackage
`default_nettype wire

// ===== sv/stp_cmd_fifo.sv =====
// Two entry command queue between the front end and the back end.
`default_nettype none
module stp_cmd_fifo
   import stp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire cmd_type wr_cmd,
   output logic         full,
   input  wire logic    rd_en,
   output cmd_type      rd_cmd,
   output logic         empty
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       do_wr;
   logic       do_rd;

   assign full   = (cnt_ff == 2'd2);
   assign empty  = (cnt_ff == 2'd0);
   assign do_wr  = wr_en && !full;
   assign do_rd  = rd_en && !empty;
   assign rd_cmd = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== sv/stp_front.sv =====
// Front end: key decoding, joint pulses, limit registers and store count.
`default_nettype none
module stp_front
   import stp_pkg::*;
#(
   parameter int SEQ_DEPTH     = 32,
   parameter int PULSE_DEFAULT = 1500,
   parameter int BASE_STEP     = 10,
   parameter int SHOULDER_STEP = 10,
   parameter int ELBOW_STEP    = 10,
   parameter int GRIP_STEP     = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  key_valid,
   input  wire logic [KEY_W-1:0]      key,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [PULSE_W-1:0]    csr_wdata,
   output logic                       cmd_push,
   output cmd_type                    cmd
);

   localparam int CW = $clog2(SEQ_DEPTH + 1);
   localparam logic [PULSE_W-1:0] PDEF = PULSE_W'(PULSE_DEFAULT);
   localparam logic [NUM_JOINTS-1:0][PULSE_W-1:0] STEPS = {
      PULSE_W'(GRIP_STEP), PULSE_W'(ELBOW_STEP), PULSE_W'(SHOULDER_STEP), PULSE_W'(BASE_STEP)
   };

   typedef enum logic [1:0] {
      MODE_MENU,
      MODE_MOVE,
      MODE_STOPPED
   } mode_type;

   mode_type           mode_ff, mode_in;
   logic [CHAN_W-1:0]  joint_ff, joint_in;
   logic [PULSE_W-1:0] pulse_ff [NUM_JOINTS];
   logic [PULSE_W-1:0] pulse_in [NUM_JOINTS];
   logic [PULSE_W-1:0] acc_ff [NUM_JOINTS];
   logic [PULSE_W-1:0] acc_in [NUM_JOINTS];
   logic [CW-1:0]      count_ff, count_in;
   logic [PULSE_W-1:0] lim_ff [NUM_LIMITS];

   logic [PULSE_W-1:0] cur_p;
   logic [PULSE_W-1:0] lo;
   logic [PULSE_W-1:0] hi;
   logic [PULSE_W-1:0] st;
   logic [PULSE_W-1:0] new_p;
   logic               hit;
   logic [CHAN_W-1:0]  hit_joint;

   assign cur_p = pulse_ff[joint_ff];
   assign lo    = lim_ff[{joint_ff, 1'b0}];
   assign hi    = lim_ff[{joint_ff, 1'b1}];
   assign st    = STEPS[joint_ff];

   // Joint key lookup used in the menu.
   always_comb begin
      hit       = 1'b0;
      hit_joint = '0;
      for (int j = 0; j < NUM_JOINTS; j++) begin
         if (!hit && (key == DOWN_KEYS[j] || key == UP_KEYS[j])) begin
            hit       = 1'b1;
            hit_joint = CHAN_W'(j);
         end
      end
   end

   // Stepped and clamped pulse for the selected joint, or its accepted pulse on reject.
   always_comb begin
      new_p = cur_p;
      if (key == DOWN_KEYS[joint_ff]) begin
         if (cur_p > lo && (cur_p - lo) >= st) begin
            new_p = cur_p - st;
         end else begin
            new_p = lo;
         end
      end else if (key == UP_KEYS[joint_ff]) begin
         if (cur_p < hi && (hi - cur_p) >= st) begin
            new_p = cur_p + st;
         end else begin
            new_p = hi;
         end
      end else if (key == KEY_REJECT) begin
         new_p = acc_ff[joint_ff];
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      joint_in = joint_ff;
      count_in = count_ff;
      for (int j = 0; j < NUM_JOINTS; j++) begin
         pulse_in[j] = pulse_ff[j];
         acc_in[j]   = acc_ff[j];
      end
      cmd_push      = 1'b0;
      cmd.op        = CMD_EMIT;
      cmd.kind      = 1'b0;
      cmd.channel   = joint_ff;
      cmd.pulse     = new_p;
      cmd.dropped   = 1'b0;
      cmd.index     = IDX_W'(count_ff);
      cmd.count     = IDX_W'(count_ff);
      if (key_valid) begin
         case (mode_ff)
            MODE_MENU: begin
               if (hit) begin
                  mode_in  = MODE_MOVE;
                  joint_in = hit_joint;
               end else if (key == KEY_RECALL) begin
                  cmd_push = 1'b1;
                  cmd.op   = CMD_RECALL;
               end else if (key == KEY_CLEAR) begin
                  cmd_push    = 1'b1;
                  cmd.kind    = 1'b1;
                  cmd.channel = '0;
                  cmd.pulse   = PDEF;
                  count_in    = '0;
                  for (int j = 0; j < NUM_JOINTS; j++) begin
                     pulse_in[j] = PDEF;
                     acc_in[j]   = PDEF;
                  end
               end else if (key == KEY_EXIT) begin
                  mode_in = MODE_STOPPED;
               end
            end
            MODE_MOVE: begin
               cmd_push           = 1'b1;
               pulse_in[joint_ff] = new_p;
               if (key == KEY_ACCEPT) begin
                  acc_in[joint_ff] = new_p;
                  mode_in          = MODE_MENU;
                  if (count_ff < CW'(SEQ_DEPTH)) begin
                     cmd.op   = CMD_STORE;
                     count_in = count_ff + CW'(1);
                  end else begin
                     cmd.dropped = 1'b1;
                  end
               end
            end
            default: begin
               mode_in = MODE_STOPPED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_MENU;
         joint_ff <= '0;
         count_ff <= '0;
         for (int j = 0; j < NUM_JOINTS; j++) begin
            pulse_ff[j] <= PDEF;
            acc_ff[j]   <= PDEF;
         end
         for (int i = 0; i < NUM_LIMITS; i++) begin
            lim_ff[i] <= i[0] ? {PULSE_W{1'b1}} : '0;
         end
      end else begin
         mode_ff  <= mode_in;
         joint_ff <= joint_in;
         count_ff <= count_in;
         for (int j = 0; j < NUM_JOINTS; j++) begin
            pulse_ff[j] <= pulse_in[j];
            acc_ff[j]   <= acc_in[j];
         end
         if (csr_we && csr_addr < CSR_ADDR_W'(NUM_LIMITS)) begin
            lim_ff[csr_addr[2:0]] <= csr_wdata;
         end
      end
   end

endmodule
`default_nettype wire

// ===== sv/stp_back.sv =====
// Back end: sequence memory, recall walk and the result register.
`default_nettype none
module stp_back
   import stp_pkg::*;
#(
   parameter int SEQ_DEPTH     = 32,
   parameter int PULSE_DEFAULT = 1500
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   input  wire logic         cmd_empty,
   output logic              cmd_pop,
   input  wire logic         out_pop,
   output logic              out_valid,
   output logic              out_kind,
   output logic [CHAN_W-1:0] out_channel,
   output logic [PULSE_W-1:0] out_pulse,
   output logic              out_dropped,
   output logic              out_last
);

   localparam int CW = $clog2(SEQ_DEPTH + 1);
   localparam int AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
   localparam int EW = CHAN_W + PULSE_W;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type          state_ff;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      cnt_ff;
   logic               valid_ff;
   logic               kind_ff;
   logic [CHAN_W-1:0]  chan_ff;
   logic [PULSE_W-1:0] pulse_ff;
   logic               drop_ff;
   logic               last_ff;

   logic [EW-1:0]      mem [SEQ_DEPTH];
   logic [EW-1:0]      rd_data_ff;
   logic               out_ready;
   logic               walk_last;

   assign out_ready = !valid_ff || out_pop;
   assign cmd_pop   = (state_ff == ST_IDLE) && !cmd_empty && out_ready;
   assign walk_last = ({{(CW > AW ? CW - AW : 0){1'b0}}, idx_ff} == CW'(cnt_ff - CW'(1)));

   // Next read address: the entry that the read data register fetches for the result register.
   always_comb begin
      idx_in = '0;
      if (state_ff == ST_WALK) begin
         if (out_ready) begin
            idx_in = walk_last ? '0 : idx_ff + AW'(1);
         end else begin
            idx_in = idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && cmd.op == CMD_STORE) begin
         mem[AW'(cmd.index)] <= {cmd.channel, cmd.pulse};
      end
      rd_data_ff <= mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         idx_ff <= idx_in;
         case (state_ff)
            ST_IDLE: begin
               if (cmd_pop) begin
                  valid_ff <= 1'b1;
                  case (cmd.op)
                     CMD_RECALL: begin
                        kind_ff  <= 1'b1;
                        chan_ff  <= '0;
                        pulse_ff <= PULSE_W'(PULSE_DEFAULT);
                        drop_ff  <= 1'b0;
                        cnt_ff   <= CW'(cmd.count);
                        last_ff  <= (cmd.count == '0);
                        if (cmd.count != '0) begin
                           state_ff <= ST_WALK;
                        end
                     end
                     default: begin
                        kind_ff  <= cmd.kind;
                        chan_ff  <= cmd.channel;
                        pulse_ff <= cmd.pulse;
                        drop_ff  <= cmd.dropped;
                        last_ff  <= 1'b1;
                     end
                  endcase
               end else if (out_pop) begin
                  valid_ff <= 1'b0;
               end
            end
            ST_WALK: begin
               // The result register is free or being taken, so the next entry moves in.
               if (out_ready) begin
                  valid_ff <= 1'b1;
                  kind_ff  <= 1'b0;
                  chan_ff  <= rd_data_ff[EW-1 -: CHAN_W];
                  pulse_ff <= rd_data_ff[PULSE_W-1:0];
                  drop_ff  <= 1'b0;
                  last_ff  <= walk_last;
                  if (walk_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign out_valid   = valid_ff;
   assign out_kind    = kind_ff;
   assign out_channel = chan_ff;
   assign out_pulse   = pulse_ff;
   assign out_dropped = drop_ff;
   assign out_last    = last_ff;

endmodule
`default_nettype wire

// ===== sv/servo_teach_playback_sequencer_core.sv =====
// Top level of the keypad teach and playback sequencer for four servo channels.
//
//   Channel    Ports                                   Direction   Handshake
//   key item   push, full, req_key                     in          push & !full
//   result     empty, pop, rsp_kind .. rsp_last        out         pop & !empty
//   limits     csr_we, csr_addr, csr_wdata             in          csr_we
//
// The front end takes one key per cycle whenever the two entry command queue has
// room. Every key except recall makes at most one result, which the back end
// places in the result register when it pops the command. A recall makes
// 1 + n results (n stored entries) at one per cycle while results are popped,
// bounded by the single read port of the sequence memory, so it occupies the
// back end until its last entry reaches the result register. Reset is synchronous
// and active high; it resets modes, pulses, limits and the store count but not
// the sequence memory, whose entries are only read below the count. A result
// left unpopped stalls the back end; the front end stalls once the queue is full.
`default_nettype none
module servo_teach_playback_sequencer_core
   import stp_pkg::*;
#(
   parameter int SEQ_DEPTH     = 32,
   parameter int PULSE_DEFAULT = 1500,
   parameter int BASE_STEP     = 10,
   parameter int SHOULDER_STEP = 10,
   parameter int ELBOW_STEP    = 10,
   parameter int GRIP_STEP     = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [KEY_W-1:0]      req_key,
   output logic                       empty,
   input  wire logic                  pop,
   output logic                       rsp_kind,
   output logic [CHAN_W-1:0]          rsp_channel,
   output logic [PULSE_W-1:0]         rsp_pulse,
   output logic                       rsp_store_dropped,
   output logic                       rsp_last,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [PULSE_W-1:0]    csr_wdata
);

   logic    key_valid;
   logic    cmd_push;
   cmd_type cmd_wr;
   cmd_type cmd_rd;
   logic    cmd_full;
   logic    cmd_empty;
   logic    cmd_pop;
   logic    out_valid;

   // A key is taken whenever the queue can hold whatever command it makes.
   assign full      = cmd_full;
   assign key_valid = push && !cmd_full;

   stp_front #(
      .SEQ_DEPTH     (SEQ_DEPTH),
      .PULSE_DEFAULT (PULSE_DEFAULT),
      .BASE_STEP     (BASE_STEP),
      .SHOULDER_STEP (SHOULDER_STEP),
      .ELBOW_STEP    (ELBOW_STEP),
      .GRIP_STEP     (GRIP_STEP)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .key_valid (key_valid),
      .key       (req_key),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd_push  (cmd_push),
      .cmd       (cmd_wr)
   );

   // Commands leave the queue in order, so a stored entry is always written
   // before any later recall reads it.
   stp_cmd_fifo u_cmd_fifo (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (cmd_push),
      .wr_cmd (cmd_wr),
      .full   (cmd_full),
      .rd_en  (cmd_pop),
      .rd_cmd (cmd_rd),
      .empty  (cmd_empty)
   );

   stp_back #(
      .SEQ_DEPTH     (SEQ_DEPTH),
      .PULSE_DEFAULT (PULSE_DEFAULT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd_rd),
      .cmd_empty   (cmd_empty),
      .cmd_pop     (cmd_pop),
      .out_pop     (pop),
      .out_valid   (out_valid),
      .out_kind    (rsp_kind),
      .out_channel (rsp_channel),
      .out_pulse   (rsp_pulse),
      .out_dropped (rsp_store_dropped),
      .out_last    (rsp_last)
   );

   assign empty = !out_valid;

endmodule
`default_nettype wire
